// ===== rtl/core/ptss_pkg.sv =====
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types and constants of the periodic trigger set scheduler: time
// format, item kinds, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package ptss_pkg;

  // Table depth default and fixed field widths
  localparam int unsigned MAX_TRIGGERS_DEF = 16;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned COUNT_W          = 5;

  // All ones in Q24.8 stands for infinity
  localparam logic [TIME_W-1:0] TIME_INF = '1;

  typedef enum logic {
    KIND_ADD     = 1'b0,
    KIND_COMPUTE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;       // capture the accepted input word
    logic add_wr;      // store a new trigger or flag the table as full
    logic scan_start;  // reset walk, earliest time := infinity
    logic scan_step;   // one step of the minimum search
    logic upd_start;   // reset walk, capture revert and advance decisions
    logic upd_step;    // one step of the revert/advance pass
    logic commit;      // take the earliest time as the pending time when advancing
    logic load_out;    // load the result word
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_add;      // held word is an add
    logic walk_done;   // table walk finished, read pipe empty
  } sts_t;

endpackage

// ===== rtl/core/ptss_if.sv =====
// ----------------------------------------------------------------------------
// ptss_if
// Valid/ready channels of the scheduler: the input word and the result word.
// ----------------------------------------------------------------------------
interface ptss_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] first_time;
  logic [31:0] final_time;
  logic [31:0] period;
  logic        additional;

  modport source (
    output valid, kind, first_time, final_time, period, additional,
    input  ready
  );
  modport sink (
    input  valid, kind, first_time, final_time, period, additional,
    output ready
  );
endinterface

interface ptss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_trigger_time;
  logic [4:0]  trigger_count;
  logic        table_full;

  modport source (
    output valid, next_trigger_time, trigger_count, table_full,
    input  ready
  );
  modport sink (
    input  valid, next_trigger_time, trigger_count, table_full,
    output ready
  );
endinterface

// ===== rtl/core/ptss_datapath.sv =====
// ----------------------------------------------------------------------------
// ptss_datapath
// Trigger table memories, walk counter, minimum search, revert/advance unit
// and the result register. Driven step by step by the controller.
// ----------------------------------------------------------------------------
module ptss_datapath #(
  parameter int unsigned MAX_TRIGGERS = ptss_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ptss_pkg::cmd_t                  cmd_i,
  output ptss_pkg::sts_t                  sts_o,
  input  logic                            kind_i,
  input  logic [ptss_pkg::TIME_W-1:0]     first_time_i,
  input  logic [ptss_pkg::TIME_W-1:0]     final_time_i,
  input  logic [ptss_pkg::TIME_W-1:0]     period_i,
  input  logic                            additional_i,
  output logic [ptss_pkg::TIME_W-1:0]     next_trigger_time_o,
  output logic [ptss_pkg::COUNT_W-1:0]    trigger_count_o,
  output logic                            table_full_o
);
  import ptss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_TRIGGERS + 1);
  localparam int unsigned IDX_W = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;

  // Held input word
  kind_e               kind_q;
  logic [TIME_W-1:0]   first_q, final_q, period_q;
  logic                extra_q;

  // Table state
  logic [TIME_W-1:0]   next_mem  [MAX_TRIGGERS];
  logic [TIME_W-1:0]   final_mem [MAX_TRIGGERS];
  logic [TIME_W-1:0]   step_mem  [MAX_TRIGGERS];
  logic [TIME_W-1:0]   saved_mem [MAX_TRIGGERS];
  logic [TIME_W-1:0]   orig_mem  [MAX_TRIGGERS];
  logic                marks_q   [MAX_TRIGGERS];
  logic [CNT_W-1:0]    held_q;
  logic [TIME_W-1:0]   pending_q;

  // Walk and search state
  logic [CNT_W-1:0]    idx_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [TIME_W-1:0]   min_q;
  logic                revert_q, adv_q, refused_q;
  logic [TIME_W-1:0]   rd_next_q, rd_final_q, rd_step_q, rd_saved_q, rd_orig_q;

  // Result word
  logic [TIME_W-1:0]   res_time_q;
  logic [COUNT_W-1:0]  res_count_q;
  logic                res_full_q;

  logic                full, add_en, walk_step, issue, upd_wr;
  logic [IDX_W-1:0]    held_idx;
  logic                restore, hit, past;
  logic [TIME_W-1:0]   base_next, base_step, sat_sum;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   upd_next, upd_step_val, upd_saved;

  assign full      = (held_q == CNT_W'(MAX_TRIGGERS));
  assign held_idx  = held_q[IDX_W-1:0];
  assign add_en    = cmd_i.add_wr && !full;
  assign walk_step = cmd_i.scan_step || cmd_i.upd_step;
  assign issue     = walk_step && (idx_q != held_q);
  assign upd_wr    = cmd_i.upd_step && rd_vld_q;

  // Revert a marked trigger, then advance any trigger that sits at the earliest time
  always_comb begin
    restore      = revert_q && marks_q[rd_idx_q];
    base_next    = restore ? rd_saved_q : rd_next_q;
    base_step    = restore ? rd_orig_q  : rd_step_q;
    hit          = adv_q && (base_next == min_q);
    sum          = {1'b0, base_next} + {1'b0, base_step};
    sat_sum      = (sum[TIME_W] || (sum[TIME_W-1:0] == TIME_INF)) ? TIME_INF
                                                                  : sum[TIME_W-1:0];
    past         = (sat_sum > rd_final_q);
    upd_next     = hit ? (past ? TIME_INF : sat_sum) : base_next;
    upd_step_val = (hit && past) ? TIME_INF : base_step;
    upd_saved    = hit ? base_next : rd_saved_q;
  end

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= kind_e'(kind_i);
      first_q  <= first_time_i;
      final_q  <= final_time_i;
      period_q <= period_i;
      extra_q  <= additional_i;
    end
  end

  // Table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (add_en) begin
      next_mem[held_idx]  <= first_q;
      final_mem[held_idx] <= final_q;
      step_mem[held_idx]  <= period_q;
      saved_mem[held_idx] <= first_q;
      orig_mem[held_idx]  <= period_q;
    end else if (upd_wr) begin
      next_mem[rd_idx_q]  <= upd_next;
      step_mem[rd_idx_q]  <= upd_step_val;
      saved_mem[rd_idx_q] <= upd_saved;
    end
    if (issue) begin
      rd_next_q  <= next_mem[idx_q[IDX_W-1:0]];
      rd_final_q <= final_mem[idx_q[IDX_W-1:0]];
      rd_step_q  <= step_mem[idx_q[IDX_W-1:0]];
      rd_saved_q <= saved_mem[idx_q[IDX_W-1:0]];
      rd_orig_q  <= orig_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Control state: count, pending time, walk, marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      pending_q <= TIME_INF;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      min_q     <= TIME_INF;
      revert_q  <= 1'b0;
      adv_q     <= 1'b0;
      refused_q <= 1'b0;
      for (int i = 0; i < MAX_TRIGGERS; i++) marks_q[i] <= 1'b0;
    end else begin
      if (cmd_i.add_wr) begin
        refused_q <= full;
        if (!full) begin
          held_q            <= held_q + CNT_W'(1);
          marks_q[held_idx] <= 1'b0;
        end
      end
      if (cmd_i.scan_start) begin
        idx_q     <= '0;
        rd_vld_q  <= 1'b0;
        min_q     <= TIME_INF;
        refused_q <= 1'b0;
      end
      // advance the walk pointer and the read pipe
      if (walk_step) begin
        rd_vld_q <= issue;
        rd_idx_q <= idx_q[IDX_W-1:0];
        if (issue) idx_q <= idx_q + CNT_W'(1);
      end
      // keep the running minimum
      if (cmd_i.scan_step && rd_vld_q && (rd_next_q < min_q)) begin
        min_q <= rd_next_q;
      end
      if (cmd_i.upd_start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        revert_q <= (min_q < pending_q);
        adv_q    <= !extra_q || (min_q < pending_q);
      end
      if (upd_wr) marks_q[rd_idx_q] <= hit;
      if (cmd_i.commit && adv_q) pending_q <= min_q;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_time_q  <= pending_q;
      res_count_q <= COUNT_W'(held_q);
      res_full_q  <= refused_q;
    end
  end

  assign sts_o.is_add     = (kind_q == KIND_ADD);
  assign sts_o.walk_done  = (idx_q == held_q) && !rd_vld_q;

  assign next_trigger_time_o = res_time_q;
  assign trigger_count_o     = res_count_q;
  assign table_full_o        = res_full_q;

endmodule

// ===== rtl/core/ptss_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptss_ctrl
// Sequencer of the scheduler: takes a word, runs the add or the two table
// passes of a compute, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ptss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ptss_pkg::sts_t  sts_i,
  output ptss_pkg::cmd_t  cmd_o
);
  import ptss_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.is_add) begin
          cmd_o.add_wr = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.walk_done) begin
          cmd_o.upd_start = 1'b1;
          state_d         = ST_UPDATE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (sts_i.walk_done) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.upd_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== rtl/core/periodic_trigger_set_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_trigger_set_scheduler_unit
// Table of periodic triggers with add and compute-next-time words.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------
//   in_i     | in  | kind, first_time, final_time, period, additional
//   out_o    | out | next_trigger_time, trigger_count, table_full
//
// An add writes the table from the dispatch state and then loads its result word.
// A compute makes two passes over the table memory port, one for the minimum
// and one for revert/advance, before its result word is loaded. The next word
// can be accepted in the cycle after the result is loaded; a finished item holds
// while the output register still waits to be taken. Reset clears the count,
// the advance marks and sets the pending time to infinity; no memory clearing.
// ----------------------------------------------------------------------------
module periodic_trigger_set_scheduler_unit #(
  parameter int unsigned MAX_TRIGGERS = ptss_pkg::MAX_TRIGGERS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptss_in_if.sink      in_i,
  ptss_out_if.source   out_o
);
  import ptss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ptss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptss_datapath #(
    .MAX_TRIGGERS (MAX_TRIGGERS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .kind_i              (in_i.kind),
    .first_time_i        (in_i.first_time),
    .final_time_i        (in_i.final_time),
    .period_i            (in_i.period),
    .additional_i        (in_i.additional),
    .next_trigger_time_o (out_o.next_trigger_time),
    .trigger_count_o     (out_o.trigger_count),
    .table_full_o        (out_o.table_full)
  );

endmodule

// ===== sim/periodic_trigger_set_scheduler_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_trigger_set_scheduler_unit_tb
// Self-checking bench for the periodic trigger set scheduler. A queue of add
// and compute words feeds a clocked driver. Every accepted word runs through
// a behavioral copy of the trigger table, and the reply it predicts is queued.
// A clocked monitor takes replies under random back-pressure and compares
// them field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module periodic_trigger_set_scheduler_unit_tb;
  import ptss_pkg::*;

  localparam int unsigned DEPTH      = MAX_TRIGGERS_DEF;
  localparam int unsigned RAND_WORDS = 600;
  localparam int unsigned CALM_WORDS = 60;

  typedef struct {
    kind_e       kind;
    logic [31:0] first_time;
    logic [31:0] final_time;
    logic [31:0] period;
    logic        additional;
  } sched_word_t;

  typedef struct {
    logic [31:0] next_time;
    logic [4:0]  count;
    logic        full;
  } sched_reply_t;

  logic clk_i;
  logic rst_ni;

  ptss_in_if  in_if ();
  ptss_out_if out_if ();

  periodic_trigger_set_scheduler_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Words waiting for the driver, replies waiting for the monitor
  sched_word_t  word_q[$];
  sched_reply_t reply_q[$];
  sched_word_t  cur_word;
  sched_reply_t want_r;

  // Shadow trigger table
  logic [31:0]      trig_next  [DEPTH];
  logic [31:0]      trig_last  [DEPTH];
  logic [31:0]      trig_step  [DEPTH];
  logic [31:0]      trig_saved [DEPTH];
  logic [31:0]      trig_step0 [DEPTH];
  logic [DEPTH-1:0] trig_moved;
  int unsigned      trig_cnt;
  logic [31:0]      pend_time;

  // Run statistics and error tally
  int unsigned n_add, n_refused, n_compute, n_revert, n_replies, fails;
  int unsigned src_gap, snk_gap;
  logic        calm;

  // Q24.8 add, saturating to infinity
  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[32] || s[31:0] == TIME_INF) return TIME_INF;
    return s[31:0];
  endfunction

  // Apply one accepted word to the shadow table and queue its reply
  function automatic void predict_schedule(input sched_word_t w);
    logic [31:0]  low;
    logic         earlier;
    logic         refused;
    sched_reply_t r;
    refused = 1'b0;
    if (w.kind == KIND_ADD) begin
      if (trig_cnt < DEPTH) begin
        trig_next[trig_cnt]  = w.first_time;
        trig_last[trig_cnt]  = w.final_time;
        trig_step[trig_cnt]  = w.period;
        trig_saved[trig_cnt] = w.first_time;
        trig_step0[trig_cnt] = w.period;
        trig_moved[trig_cnt] = 1'b0;
        trig_cnt++;
        n_add++;
      end else begin
        refused = 1'b1;
        n_refused++;
      end
    end else begin
      n_compute++;
      // Find the earliest next time before any revert
      low = TIME_INF;
      for (int i = 0; i < trig_cnt; i++)
        if (trig_next[i] < low) low = trig_next[i];
      earlier = (low < pend_time);
      // Undo the previous advance when an earlier time showed up
      if (earlier) begin
        if (trig_moved != '0) n_revert++;
        for (int i = 0; i < trig_cnt; i++) begin
          if (trig_moved[i]) begin
            trig_next[i] = trig_saved[i];
            trig_step[i] = trig_step0[i];
          end
        end
      end
      trig_moved = '0;
      // Advance every trigger sitting at the earliest time
      if (!w.additional || earlier) begin
        for (int i = 0; i < trig_cnt; i++) begin
          if (trig_next[i] == low) begin
            trig_saved[i] = trig_next[i];
            trig_next[i]  = sat_sum(trig_next[i], trig_step[i]);
            if (trig_next[i] > trig_last[i]) begin
              trig_next[i] = TIME_INF;
              trig_step[i] = TIME_INF;
            end
            trig_moved[i] = 1'b1;
          end
        end
        pend_time = low;
      end
    end
    r.next_time = pend_time;
    r.count     = trig_cnt[4:0];
    r.full      = refused;
    reply_q = {reply_q, r};
  endfunction

  function automatic void queue_add(input logic [31:0] f, input logic [31:0] l,
                                    input logic [31:0] p);
    sched_word_t w;
    w.kind       = KIND_ADD;
    w.first_time = f;
    w.final_time = l;
    w.period     = p;
    w.additional = 1'($urandom_range(0, 1));
    word_q = {word_q, w};
  endfunction

  // Compute words carry random junk in the unused fields
  function automatic void queue_compute(input logic extra);
    sched_word_t w;
    w.kind       = KIND_COMPUTE;
    w.first_time = $urandom;
    w.final_time = $urandom;
    w.period     = $urandom;
    w.additional = extra;
    word_q = {word_q, w};
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: predict on accept, then present the next word or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      src_gap = 0;
      in_if.valid      <= 1'b0;
      in_if.kind       <= KIND_ADD;
      in_if.first_time <= '0;
      in_if.final_time <= '0;
      in_if.period     <= '0;
      in_if.additional <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_schedule(cur_word);
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (word_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.kind       <= cur_word.kind;
          in_if.first_time <= cur_word.first_time;
          in_if.final_time <= cur_word.final_time;
          in_if.period     <= cur_word.period;
          in_if.additional <= cur_word.additional;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted reply, then stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      snk_gap = 0;
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_replies++;
        if (reply_q.size() == 0) begin
          $display("%0t: reply with none due: time %h count %0d full %0b", $time,
                   out_if.next_trigger_time, out_if.trigger_count, out_if.table_full);
          fails++;
        end else begin
          want_r = reply_q.pop_front();
          if (out_if.next_trigger_time !== want_r.next_time) begin
            $display("%0t: next_trigger_time expected %h actual %h", $time,
                     want_r.next_time, out_if.next_trigger_time);
            fails++;
          end
          if (out_if.trigger_count !== want_r.count) begin
            $display("%0t: trigger_count expected %0d actual %0d", $time,
                     want_r.count, out_if.trigger_count);
            fails++;
          end
          if (out_if.table_full !== want_r.full) begin
            $display("%0t: table_full expected %0b actual %0b", $time,
                     want_r.full, out_if.table_full);
            fails++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] f, l, p, room;
    rst_ni           = 1'b0;
    calm             = 1'b0;
    trig_cnt         = 0;
    trig_moved       = '0;
    pend_time        = TIME_INF;
    n_add = 0; n_refused = 0; n_compute = 0; n_revert = 0; n_replies = 0; fails = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, plain and additional
    queue_compute(1'b0);
    queue_compute(1'b1);
    // Only an infinite trigger with a finite last time
    queue_add(TIME_INF, 32'h0, 32'h0);
    queue_compute(1'b0);
    // Two triggers at zero, one of them bounded
    queue_add(32'h0, TIME_INF, 32'h100);
    queue_add(32'h0, 32'h300, 32'h80);
    queue_compute(1'b0);
    queue_compute(1'b1);
    queue_compute(1'b0);
    // Earlier trigger arrives: revert on an additional compute
    queue_add(32'h40, TIME_INF, TIME_INF);
    queue_compute(1'b1);
    // Saturation to infinity and a trigger that sits at its last time
    queue_add(32'hFFFF_FFFE, TIME_INF, 32'h1);
    queue_add(32'h10, 32'h10, 32'h20);
    queue_compute(1'b1);
    repeat (6) queue_compute(1'b0);
    queue_compute(1'b1);
    queue_compute(1'b0);

    // Random part: mostly computes, with adds often placed just before the pending time
    for (int n = 0; n < RAND_WORDS; n++) begin
      while (word_q.size() > 1) @(posedge clk_i);
      if (n == RAND_WORDS - CALM_WORDS) calm = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        if (pend_time != TIME_INF && pend_time != 0 && $urandom_range(0, 2) != 0) begin
          room = (pend_time < 32'h400) ? pend_time : 32'h400;
          f = pend_time - $urandom_range(1, room);
        end else if ($urandom_range(0, 1) == 1) begin
          f = $urandom;
        end else begin
          f = $urandom_range(0, 32'h1000);
        end
        case ($urandom_range(0, 3))
          0, 1:    l = TIME_INF;
          2:       l = sat_sum(f, $urandom_range(0, 32'h4000));
          default: l = $urandom;
        endcase
        p = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 32'h180);
        queue_add(f, l, p);
      end else begin
        queue_compute(1'($urandom_range(0, 1)));
      end
    end

    // Drain the input side, then the replies, then let the block settle
    while (word_q.size() > 0 || in_if.valid) @(posedge clk_i);
    while (reply_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Run covered %0d adds (%0d refused on a full table), %0d computes,",
             n_add, n_refused, n_compute);
    $display("%0d reverts of advanced triggers; %0d replies checked, %0d mismatches.",
             n_revert, n_replies, fails);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d replies still due", $time, reply_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ptss_pkg.sv
rtl/core/ptss_if.sv
rtl/core/ptss_datapath.sv
rtl/core/ptss_ctrl.sv
rtl/core/periodic_trigger_set_scheduler_unit.sv
sim/periodic_trigger_set_scheduler_unit_tb.sv
